@@ rtl/core/mls_pkg.sv @@
// Shared types, phase codes, message codes and register indexes of the modem link supervisor.
// Used by every module of the block; has no dependencies of its own.
package mls_pkg;

   // Modem machine phases.
   localparam logic [2:0] MP_ANNOUNCE   = 3'd0;
   localparam logic [2:0] MP_WAIT_READY = 3'd1;
   localparam logic [2:0] MP_SETTLE     = 3'd2;
   localparam logic [2:0] MP_IDLE       = 3'd3;

   // Link machine phases.
   localparam logic [2:0] LP_CONTACT_START = 3'd0;
   localparam logic [2:0] LP_CONTACT_WAIT  = 3'd1;
   localparam logic [2:0] LP_TIMECHECK     = 3'd2;
   localparam logic [2:0] LP_IDLE          = 3'd3;
   localparam logic [2:0] LP_HB_WAIT       = 3'd4;

   // Pending acknowledge bits.
   localparam logic [2:0] ACK_CONTACT = 3'b001;
   localparam logic [2:0] ACK_TIME    = 3'b010;
   localparam logic [2:0] ACK_HB      = 3'b100;

   // Message codes.
   localparam logic [1:0] MSG_NONE    = 2'd0;
   localparam logic [1:0] MSG_CONTACT = 2'd1;
   localparam logic [1:0] MSG_TIME    = 2'd2;
   localparam logic [1:0] MSG_HB      = 2'd3;

   localparam logic [15:0] CONTACT_SHORT_TICKS = 16'd60;

   // Configuration register indexes.
   localparam logic [7:0] CSR_POWER_TIMEOUT     = 8'd0;
   localparam logic [7:0] CSR_SETTLE            = 8'd1;
   localparam logic [7:0] CSR_IP_CHANGE_TIMEOUT = 8'd2;
   localparam logic [7:0] CSR_CONTACT_RETRY     = 8'd3;
   localparam logic [7:0] CSR_CHECKTIME_RETRY   = 8'd4;
   localparam logic [7:0] CSR_HEARTBEAT_RETRY   = 8'd5;
   localparam logic [7:0] CSR_HEARTBEAT_TRIES   = 8'd6;
   localparam logic [7:0] CSR_LINK_ERROR_LIMIT  = 8'd7;

   // One poll pass; tick sits in the lowest bit.
   typedef struct packed {
      logic ip_change_done;
      logic ip_change_request;
      logic modem_powered;
      logic modem_ready;
      logic heartbeat_ack;
      logic time_ack;
      logic contact_ack;
      logic heartbeat_due;
      logic tick;
   } req_item_type;

   // One result; send_message sits in the lowest bits.
   typedef struct packed {
      logic       ip_change_finished;
      logic       uart_restart;
      logic       modem_up;
      logic       link_up;
      logic       power_on_request;
      logic       modem_reset;
      logic [1:0] send_message;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] power_timeout_ticks;
      logic [15:0] settle_ticks;
      logic [15:0] ip_change_timeout_ticks;
      logic [15:0] contact_retry_ticks;
      logic [15:0] checktime_retry_ticks;
      logic [15:0] heartbeat_retry_ticks;
      logic [3:0]  heartbeat_max_tries;
      logic [7:0]  link_error_limit;
   } cfg_type;

   // Side effects of one modem machine pass.
   typedef struct packed {
      logic modem_reset;
      logic power_on_request;
      logic ip_change_finished;
      logic link_down;
   } modem_ctl_type;

   // Side effects of one link machine pass.
   typedef struct packed {
      logic [1:0] send_message;
      logic       uart_restart;
      logic       force_modem_idle;
   } link_ctl_type;

   function automatic logic [7:0] sat_inc8(input logic [7:0] value);
      logic [7:0] result;
      result = (value == 8'hff) ? value : value + 8'd1;
      return result;
   endfunction

endpackage

@@ rtl/core/mls_modem_step.sv @@
// Modem machine: power-up, ready wait with timeout, settle or address change wait.
// Pure next-state logic; depends on mls_pkg.
module mls_modem_step
   import mls_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  cfg_type               cfg,
   input  req_item_type          item,
   input  logic [2:0]            phase,
   input  logic                  up_flag,
   input  logic [TIMER_BITS-1:0] timer,
   input  logic [7:0]            error_count,
   input  logic                  ip_pending,
   output logic [2:0]            phase_next,
   output logic                  up_flag_next,
   output logic [TIMER_BITS-1:0] timer_next,
   output logic [7:0]            error_count_next,
   output logic                  ip_pending_next,
   output modem_ctl_type         ctl
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic [CMP_W-1:0] timer_x;

   assign timer_x = CMP_W'(timer);

   always_comb begin
      phase_next       = phase;
      up_flag_next     = up_flag;
      timer_next       = timer;
      error_count_next = error_count;
      ip_pending_next  = ip_pending;
      ctl              = '0;
      case (phase)
         MP_IDLE: begin
            // Address change or up flag low: modem reset; a change drops the link.
            if (ip_pending || !up_flag) begin
               ctl.modem_reset = 1'b1;
               ctl.link_down   = ip_pending;
               up_flag_next    = 1'b0;
               timer_next      = '0;
               phase_next      = MP_WAIT_READY;
            end
         end
         MP_ANNOUNCE: begin
            phase_next = MP_WAIT_READY;
            timer_next = '0;
         end
         MP_WAIT_READY: begin
            ctl.power_on_request = !item.modem_powered;
            if (item.modem_ready) begin
               phase_next       = MP_SETTLE;
               timer_next       = '0;
               error_count_next = '0;
            end else if (timer_x >= CMP_W'(cfg.power_timeout_ticks)) begin
               ctl.modem_reset  = 1'b1;
               timer_next       = '0;
               error_count_next = sat_inc8(error_count);
            end
         end
         MP_SETTLE: begin
            if (ip_pending) begin
               if (item.ip_change_done) begin
                  up_flag_next           = 1'b1;
                  phase_next             = MP_IDLE;
                  timer_next             = '0;
                  ip_pending_next        = 1'b0;
                  error_count_next       = '0;
                  ctl.ip_change_finished = 1'b1;
               end else if (timer_x >= CMP_W'(cfg.ip_change_timeout_ticks)) begin
                  ctl.modem_reset  = 1'b1;
                  phase_next       = MP_ANNOUNCE;
                  error_count_next = sat_inc8(error_count);
               end
            end else if (timer_x >= CMP_W'(cfg.settle_ticks)) begin
               up_flag_next = 1'b1;
               phase_next   = MP_IDLE;
               timer_next   = '0;
            end
         end
         default: begin
            ctl.modem_reset = 1'b1;
            timer_next      = '0;
            phase_next      = MP_ANNOUNCE;
         end
      endcase
   end

endmodule

@@ rtl/core/mls_link_step.sv @@
// Link machine: contact message, time check, heartbeats with retries and failure counting.
// Pure next-state logic; depends on mls_pkg.
module mls_link_step
   import mls_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  cfg_type               cfg,
   input  logic [2:0]            phase,
   input  logic                  up_flag,
   input  logic [TIMER_BITS-1:0] timer,
   input  logic [3:0]            retry_count,
   input  logic [7:0]            error_count,
   input  logic [2:0]            pending,
   input  logic                  hb_request,
   output logic [2:0]            phase_next,
   output logic                  up_flag_next,
   output logic [TIMER_BITS-1:0] timer_next,
   output logic [3:0]            retry_count_next,
   output logic [7:0]            error_count_next,
   output logic [2:0]            pending_next,
   output logic                  hb_request_next,
   output link_ctl_type          ctl
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic [CMP_W-1:0] timer_x;
   logic [3:0]       retry_inc;
   logic [7:0]       error_inc;

   assign timer_x   = CMP_W'(timer);
   assign retry_inc = retry_count + 4'd1;
   assign error_inc = sat_inc8(error_count);

   always_comb begin
      phase_next       = phase;
      up_flag_next     = up_flag;
      timer_next       = timer;
      retry_count_next = retry_count;
      error_count_next = error_count;
      pending_next     = pending;
      hb_request_next  = hb_request;
      ctl              = '0;
      ctl.send_message = MSG_NONE;
      case (phase)
         LP_IDLE: begin
            if (hb_request) begin
               ctl.send_message = MSG_HB;
               pending_next     = pending | ACK_HB;
               hb_request_next  = 1'b0;
               phase_next       = LP_HB_WAIT;
               timer_next       = '0;
               up_flag_next     = 1'b0;
               retry_count_next = '0;
            end
         end
         LP_HB_WAIT: begin
            if ((pending & ACK_HB) == 3'b000) begin
               phase_next       = LP_IDLE;
               error_count_next = '0;
               up_flag_next     = 1'b1;
               retry_count_next = '0;
            end else if (timer_x >= CMP_W'(cfg.heartbeat_retry_ticks)) begin
               retry_count_next = retry_inc;
               if (retry_inc < cfg.heartbeat_max_tries) begin
                  ctl.send_message = MSG_HB;
                  pending_next     = pending | ACK_HB;
                  timer_next       = '0;
                  ctl.uart_restart = error_count > cfg.link_error_limit;
               end else begin
                  // One more heartbeat failure; at the limit the modem is restarted.
                  error_count_next     = error_inc;
                  ctl.force_modem_idle = error_inc >= cfg.link_error_limit;
                  phase_next           = LP_IDLE;
                  up_flag_next         = 1'b0;
                  ctl.uart_restart     = error_inc > cfg.link_error_limit;
               end
            end
         end
         LP_CONTACT_START: begin
            ctl.send_message = MSG_CONTACT;
            pending_next     = pending | ACK_CONTACT;
            timer_next       = '0;
            up_flag_next     = 1'b0;
            phase_next       = LP_CONTACT_WAIT;
            retry_count_next = '0;
         end
         LP_CONTACT_WAIT: begin
            if (timer_x >= CMP_W'(cfg.contact_retry_ticks) ||
                timer_x >= CMP_W'(CONTACT_SHORT_TICKS)) begin
               timer_next       = '0;
               ctl.send_message = MSG_CONTACT;
               pending_next     = pending | ACK_CONTACT;
            end else if ((pending & ACK_CONTACT) == 3'b000) begin
               ctl.send_message = MSG_TIME;
               pending_next     = pending | ACK_TIME;
               timer_next       = '0;
               phase_next       = LP_TIMECHECK;
            end
         end
         LP_TIMECHECK: begin
            if (timer_x >= CMP_W'(cfg.checktime_retry_ticks)) begin
               timer_next       = '0;
               ctl.send_message = MSG_TIME;
               pending_next     = pending | ACK_TIME;
            end else if ((pending & ACK_TIME) == 3'b000) begin
               ctl.send_message = MSG_HB;
               pending_next     = pending | ACK_HB;
               phase_next       = LP_HB_WAIT;
               timer_next       = '0;
               hb_request_next  = 1'b0;
            end
         end
         default: begin
            phase_next = LP_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/modem_link_supervisor_core.sv @@
// Top level of the modem link supervisor: handshakes, configuration and state registers.
// Depends on mls_pkg, mls_modem_step and mls_link_step.
//
// Usage: every beat on the req_ channel is one poll pass of the supervisor, carrying a
// tick flag and the modem and partner status bits. Every accepted beat yields exactly one
// beat on the rsp_ channel with the message to send now, the modem reset, power and UART
// restart requests and the modem up and link up flags.
// A beat is first captured in an input register. Once the output register is free or
// draining, the modem and link machines run on it and the result is written to an output
// register, from which it shows on rsp_. One beat enters every cycle while rsp_tready stays
// high; the throughput is then one poll pass per clock cycle.
// When the receiver stalls, the result waits in the output register, the next beat waits
// in the input register, and req_tready falls only once both are occupied.
// The csr_ channel writes one of the eight timing and limit registers per beat and is
// always ready; it is meant to be written while no poll pass is in flight.
// A synchronous, active-high reset restores the register defaults (700, 60, 200, 600,
// 120, 30, 3 and 10), puts the modem machine in its announce phase, the link machine in
// its contact phase, clears all timers, counters and flags and empties both registers.
// Timers saturate at all ones of TIMER_BITS; error counters saturate at 255.
module modem_link_supervisor_core
   import mls_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: tick, heartbeat_due, contact_ack, time_ack, heartbeat_ack, modem_ready,
   // modem_powered, ip_change_request, ip_change_done, then seven unused bits.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: send_message[1:0], modem_reset, power_on_request, link_up, modem_up,
   // uart_restart, ip_change_finished.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   // Handshake registers.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         fire;

   cfg_type cfg_ff, cfg_in;

   // Machine state.
   logic [2:0]            modem_phase_ff, modem_phase_in;
   logic                  modem_up_ff, modem_up_in;
   logic [TIMER_BITS-1:0] modem_timer_ff, modem_timer_in;
   logic [7:0]            modem_errors_ff, modem_errors_in;
   logic [2:0]            link_phase_ff, link_phase_in;
   logic                  link_up_ff, link_up_in;
   logic [TIMER_BITS-1:0] link_timer_ff, link_timer_in;
   logic [3:0]            retry_count_ff, retry_count_in;
   logic [7:0]            link_errors_ff, link_errors_in;
   logic [2:0]            pending_ff, pending_in;
   logic                  hb_request_ff, hb_request_in;
   logic                  ip_pending_ff, ip_pending_in;

   // Values after the tick, acknowledge and request latching of this poll pass.
   logic [TIMER_BITS-1:0] modem_timer_t, link_timer_t;
   logic [2:0]            pending_t;
   logic                  hb_request_t, ip_pending_t;

   // Modem machine outputs.
   logic [2:0]            m_phase;
   logic                  m_up;
   logic [TIMER_BITS-1:0] m_timer;
   logic [7:0]            m_errors;
   logic                  m_ip_pending;
   modem_ctl_type         m_ctl;

   // Link machine outputs.
   logic                  link_up_m;
   logic [2:0]            l_phase;
   logic                  l_up;
   logic [TIMER_BITS-1:0] l_timer;
   logic [3:0]            l_retry;
   logic [7:0]            l_errors;
   logic [2:0]            l_pending;
   logic                  l_hb_request;
   link_ctl_type          l_ctl;

   // The poll pass in the input register runs once the output register is free or draining.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_item_ff;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign in_item_in   = (req_tvalid && req_tready) ? req_tdata[8:0] : in_item_ff;
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POWER_TIMEOUT:     cfg_in.power_timeout_ticks     = csr_data;
            CSR_SETTLE:            cfg_in.settle_ticks            = csr_data;
            CSR_IP_CHANGE_TIMEOUT: cfg_in.ip_change_timeout_ticks = csr_data;
            CSR_CONTACT_RETRY:     cfg_in.contact_retry_ticks     = csr_data;
            CSR_CHECKTIME_RETRY:   cfg_in.checktime_retry_ticks   = csr_data;
            CSR_HEARTBEAT_RETRY:   cfg_in.heartbeat_retry_ticks   = csr_data;
            CSR_HEARTBEAT_TRIES:   cfg_in.heartbeat_max_tries     = csr_data[3:0];
            CSR_LINK_ERROR_LIMIT:  cfg_in.link_error_limit        = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Ticks advance both timers, acknowledges clear pending bits and requests latch.
   always_comb begin
      modem_timer_t = modem_timer_ff;
      link_timer_t  = link_timer_ff;
      if (in_item_ff.tick) begin
         if (modem_timer_ff != TIMER_MAX) begin
            modem_timer_t = modem_timer_ff + TIMER_BITS'(1);
         end
         if (link_timer_ff != TIMER_MAX) begin
            link_timer_t = link_timer_ff + TIMER_BITS'(1);
         end
      end
      pending_t = pending_ff & ~{in_item_ff.heartbeat_ack, in_item_ff.time_ack,
                                 in_item_ff.contact_ack};
      hb_request_t = hb_request_ff || in_item_ff.heartbeat_due;
      ip_pending_t = ip_pending_ff || in_item_ff.ip_change_request;
   end

   mls_modem_step #(
      .TIMER_BITS(TIMER_BITS)
   ) u_modem (
      .cfg              (cfg_ff),
      .item             (in_item_ff),
      .phase            (modem_phase_ff),
      .up_flag          (modem_up_ff),
      .timer            (modem_timer_t),
      .error_count      (modem_errors_ff),
      .ip_pending       (ip_pending_t),
      .phase_next       (m_phase),
      .up_flag_next     (m_up),
      .timer_next       (m_timer),
      .error_count_next (m_errors),
      .ip_pending_next  (m_ip_pending),
      .ctl              (m_ctl)
   );

   assign link_up_m = link_up_ff && !m_ctl.link_down;

   mls_link_step #(
      .TIMER_BITS(TIMER_BITS)
   ) u_link (
      .cfg              (cfg_ff),
      .phase            (link_phase_ff),
      .up_flag          (link_up_m),
      .timer            (link_timer_t),
      .retry_count      (retry_count_ff),
      .error_count      (link_errors_ff),
      .pending          (pending_t),
      .hb_request       (hb_request_t),
      .phase_next       (l_phase),
      .up_flag_next     (l_up),
      .timer_next       (l_timer),
      .retry_count_next (l_retry),
      .error_count_next (l_errors),
      .pending_next     (l_pending),
      .hb_request_next  (l_hb_request),
      .ctl              (l_ctl)
   );

   // A heartbeat failure at the limit overrides the modem machine: idle with modem down.
   always_comb begin
      modem_phase_in  = modem_phase_ff;
      modem_up_in     = modem_up_ff;
      modem_timer_in  = modem_timer_ff;
      modem_errors_in = modem_errors_ff;
      link_phase_in   = link_phase_ff;
      link_up_in      = link_up_ff;
      link_timer_in   = link_timer_ff;
      retry_count_in  = retry_count_ff;
      link_errors_in  = link_errors_ff;
      pending_in      = pending_ff;
      hb_request_in   = hb_request_ff;
      ip_pending_in   = ip_pending_ff;
      if (fire) begin
         modem_phase_in  = l_ctl.force_modem_idle ? MP_IDLE : m_phase;
         modem_up_in     = m_up && !l_ctl.force_modem_idle;
         modem_timer_in  = m_timer;
         modem_errors_in = m_errors;
         link_phase_in   = l_phase;
         link_up_in      = l_up;
         link_timer_in   = l_timer;
         retry_count_in  = l_retry;
         link_errors_in  = l_errors;
         pending_in      = l_pending;
         hb_request_in   = l_hb_request;
         ip_pending_in   = m_ip_pending;
      end
   end

   always_comb begin
      out_item_in = out_item_ff;
      if (fire) begin
         out_item_in.send_message       = l_ctl.send_message;
         out_item_in.modem_reset        = m_ctl.modem_reset;
         out_item_in.power_on_request   = m_ctl.power_on_request;
         out_item_in.link_up            = l_up;
         out_item_in.modem_up           = m_up && !l_ctl.force_modem_idle;
         out_item_in.uart_restart       = l_ctl.uart_restart;
         out_item_in.ip_change_finished = m_ctl.ip_change_finished;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         cfg_ff.power_timeout_ticks     <= 16'd700;
         cfg_ff.settle_ticks            <= 16'd60;
         cfg_ff.ip_change_timeout_ticks <= 16'd200;
         cfg_ff.contact_retry_ticks     <= 16'd600;
         cfg_ff.checktime_retry_ticks   <= 16'd120;
         cfg_ff.heartbeat_retry_ticks   <= 16'd30;
         cfg_ff.heartbeat_max_tries     <= 4'd3;
         cfg_ff.link_error_limit        <= 8'd10;
         modem_phase_ff  <= MP_ANNOUNCE;
         modem_up_ff     <= 1'b0;
         modem_timer_ff  <= '0;
         modem_errors_ff <= '0;
         link_phase_ff   <= LP_CONTACT_START;
         link_up_ff      <= 1'b0;
         link_timer_ff   <= '0;
         retry_count_ff  <= '0;
         link_errors_ff  <= '0;
         pending_ff      <= '0;
         hb_request_ff   <= 1'b0;
         ip_pending_ff   <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         cfg_ff          <= cfg_in;
         modem_phase_ff  <= modem_phase_in;
         modem_up_ff     <= modem_up_in;
         modem_timer_ff  <= modem_timer_in;
         modem_errors_ff <= modem_errors_in;
         link_phase_ff   <= link_phase_in;
         link_up_ff      <= link_up_in;
         link_timer_ff   <= link_timer_in;
         retry_count_ff  <= retry_count_in;
         link_errors_ff  <= link_errors_in;
         pending_ff      <= pending_in;
         hb_request_ff   <= hb_request_in;
         ip_pending_ff   <= ip_pending_in;
      end
   end

   // The modem is only ever declared up while its machine sits in the idle phase.
   a_modem_up_idle: assert property (@(posedge clock) disable iff (reset)
      modem_up_ff |-> modem_phase_ff == MP_IDLE)
      else $error("modem up outside the idle phase");

   // A heartbeat send always leaves the link machine waiting for its acknowledge.
   a_hb_wait: assert property (@(posedge clock) disable iff (reset)
      fire && l_ctl.send_message == MSG_HB |=> link_phase_ff == LP_HB_WAIT)
      else $error("heartbeat sent without entering the heartbeat wait");

   // A UART restart comes only from a failing heartbeat exchange, with the link down.
   a_uart_link_down: assert property (@(posedge clock) disable iff (reset)
      fire && l_ctl.uart_restart |-> !l_up)
      else $error("UART restart requested while the link is up");

   // A modem reset never goes out together with the modem up flag.
   a_reset_not_up: assert property (@(posedge clock) disable iff (reset)
      fire && m_ctl.modem_reset |-> !m_up)
      else $error("modem reset while the modem is declared up");

endmodule
